>>> rtl/core/ipv6_neighbor_cache_core_defines.svh
// Assertion macros for the IPv6 neighbor cache core.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef IPV6_NEIGHBOR_CACHE_CORE_DEFINES_SVH
`define IPV6_NEIGHBOR_CACHE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPV6NC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv6 neighbor cache core: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IPV6NC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv6 neighbor cache core: assertion failed");

`endif

>>> rtl/core/ipv6nc_pkg.sv
`timescale 1ns / 1ps

package ipv6nc_pkg;

    // Table geometry
    localparam int NUM_PORTS     = 4;
    localparam int CACHE_ENTRIES = 64;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int PORT_W   = 2;
    localparam int KEY_W    = 64;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LEARN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SOLICIT = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_MATCH = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Query token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic                valid;
        logic                port_ok;
        logic [ACTION_W-1:0] action;
        logic [PIDX_W-1:0]   port;
        logic [KEY_W-1:0]    key_high;
        logic [KEY_W-1:0]    key_low;
        logic [MAC_W-1:0]    mac_in;
        logic [FILL_W-1:0]   fill;
        logic [FILL_W-1:0]   pos;
        logic                found;
        logic                added;
        logic [MAC_W-1:0]    mac_res;
    } token_t;

    // Port field to table index, zero-extended or truncated as needed
    function automatic logic [PIDX_W-1:0] to_pidx(input logic [PORT_W-1:0] p);
        logic [PIDX_W+PORT_W-1:0] ext;
        ext = {{PIDX_W{1'b0}}, p};
        return ext[PIDX_W-1:0];
    endfunction

endpackage

>>> rtl/core/ipv6nc_cell.sv
`timescale 1ns / 1ps

// One table slot for every port. The token compares against the slot of its
// port, may update or append it, and moves to the next cell.
module ipv6nc_cell
    import ipv6nc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    output token_t tok_out
);

    // Slot storage, one entry per port, no reset
    logic [KEY_W-1:0] key_high_reg  [NUM_PORTS];
    logic [KEY_W-1:0] key_low_reg   [NUM_PORTS];
    logic [MAC_W-1:0] mac_reg       [NUM_PORTS];
    logic             reachable_reg [NUM_PORTS];

    logic   valid_reg;
    token_t tok_reg;
    token_t tok_next;

    logic is_learn;
    logic is_solicit;
    logic is_lookup;
    logic in_range;
    logic at_slot;
    logic hit_any;
    logic hit_reach;
    logic wr_update;
    logic wr_append;

    // Match and update decisions for this slot
    always_comb
    begin
        is_learn   = (tok_in.action == ACT_LEARN);
        is_solicit = (tok_in.action == ACT_SOLICIT);
        is_lookup  = !(is_learn || is_solicit);
        in_range   = (tok_in.pos < tok_in.fill);
        at_slot    = (tok_in.pos == tok_in.fill);
        hit_any    = in_range
                     && (key_high_reg[tok_in.port] == tok_in.key_high)
                     && (key_low_reg[tok_in.port] == tok_in.key_low);
        hit_reach  = hit_any && reachable_reg[tok_in.port];

        wr_update = tok_in.valid && tok_in.port_ok && is_learn && !tok_in.found && hit_any;
        wr_append = tok_in.valid && tok_in.port_ok && (is_learn || is_solicit)
                    && !tok_in.found && at_slot;

        tok_next     = tok_in;
        tok_next.pos = tok_in.pos + FILL_W'(1);
        if (tok_in.port_ok && !tok_in.found)
        begin
            if ((is_learn || is_solicit) && hit_any)
            begin
                tok_next.found = 1'b1;
            end
            else if (is_lookup && hit_reach)
            begin
                tok_next.found   = 1'b1;
                tok_next.mac_res = mac_reg[tok_in.port];
            end
            else if ((is_learn || is_solicit) && at_slot)
            begin
                tok_next.added = 1'b1;
            end
        end
    end

    // Slot write: learn refresh or append
    always_ff @(posedge clk)
    begin
        if (wr_update)
        begin
            mac_reg[tok_in.port]       <= tok_in.mac_in;
            reachable_reg[tok_in.port] <= 1'b1;
        end
        else if (wr_append)
        begin
            key_high_reg[tok_in.port]  <= tok_in.key_high;
            key_low_reg[tok_in.port]   <= tok_in.key_low;
            mac_reg[tok_in.port]       <= is_learn ? tok_in.mac_in : '0;
            reachable_reg[tok_in.port] <= is_learn;
        end
    end

    // Token hand-off to the neighbor, payload every cycle
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

>>> rtl/core/ipv6_neighbor_cache_core.sv
// IPv6 neighbor cache: one item at a time walks a chain of CACHE_ENTRIES cells.
// A new item is accepted only once the previous one has left the end of the chain.
// Reset clears the fill counts, busy flag and output valid; entry storage is
// not cleared and is only read below a port's fill count.
`timescale 1ns / 1ps
`include "ipv6_neighbor_cache_core_defines.svh"

module ipv6_neighbor_cache_core
    import ipv6nc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [PORT_W-1:0]   port,
    input  logic [KEY_W-1:0]    key_high,
    input  logic [KEY_W-1:0]    key_low,
    input  logic [MAC_W-1:0]    mac_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [MAC_W-1:0]    mac_out
);

    logic [FILL_W-1:0]   fill_reg [NUM_PORTS];
    logic                busy_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [MAC_W-1:0]    mac_out_reg;
    logic [STATUS_W-1:0] status_next;
    logic [MAC_W-1:0]    mac_out_next;

    logic              in_acc;
    logic              launch_ok;
    logic [PIDX_W-1:0] launch_pidx;
    logic              end_modify;
    token_t            chain [CACHE_ENTRIES+1];
    token_t            chain_out;

    // Input handshake: one item in flight, output register may still drain
    assign in_stall = busy_reg || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    // Token launch
    assign launch_ok   = (int'(port) < NUM_PORTS);
    assign launch_pidx = to_pidx(port);

    always_comb
    begin
        chain[0].valid    = in_acc;
        chain[0].port_ok  = launch_ok;
        chain[0].action   = action;
        chain[0].port     = launch_pidx;
        chain[0].key_high = key_high;
        chain[0].key_low  = key_low;
        chain[0].mac_in   = mac_in;
        chain[0].fill     = launch_ok ? fill_reg[launch_pidx] : '0;
        chain[0].pos      = '0;
        chain[0].found    = 1'b0;
        chain[0].added    = 1'b0;
        chain[0].mac_res  = '0;
    end

    // Cell chain
    for (genvar gi = 0; gi < CACHE_ENTRIES; gi++)
    begin : g_cell
        ipv6nc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[gi]),
            .tok_out (chain[gi+1])
        );
    end

    assign chain_out = chain[CACHE_ENTRIES];

    // Result from the token at the end of the chain
    always_comb
    begin
        end_modify   = (chain_out.action == ACT_LEARN) || (chain_out.action == ACT_SOLICIT);
        mac_out_next = chain_out.mac_res;
        if (!chain_out.port_ok)
        begin
            status_next = end_modify ? ST_FULL : ST_MISS;
        end
        else if (chain_out.found)
        begin
            status_next = ST_MATCH;
        end
        else if (chain_out.added)
        begin
            status_next = ST_ADDED;
        end
        else
        begin
            status_next = end_modify ? ST_FULL : ST_MISS;
        end
    end

    // Control state and fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (chain_out.valid)
            begin
                busy_reg <= 1'b0;
            end

            if (chain_out.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (chain_out.valid && chain_out.added)
            begin
                fill_reg[chain_out.port] <= chain_out.fill + FILL_W'(1);
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (chain_out.valid)
        begin
            status_reg  <= status_next;
            mac_out_reg <= mac_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign mac_out   = mac_out_reg;

    // Checks
    `IPV6NC_ASSERT_NOW(a_found_added_excl, chain_out.valid, !(chain_out.found && chain_out.added))
    `IPV6NC_ASSERT_NOW(a_append_has_room, chain_out.valid && chain_out.added,
                       chain_out.fill < FILL_W'(CACHE_ENTRIES))
    `IPV6NC_ASSERT_NOW(a_out_reg_free, chain_out.valid, !out_valid_reg || !out_stall)
    `IPV6NC_ASSERT_NOW(a_done_gives_result, $fell(busy_reg), out_valid_reg)

endmodule
